### src/midi_channel_message_decoder_unit_macros.svh
// Assertion macros shared by the decoder RTL.
`ifndef MIDI_CHANNEL_MESSAGE_DECODER_UNIT_MACROS_SVH
`define MIDI_CHANNEL_MESSAGE_DECODER_UNIT_MACROS_SVH

// Same-cycle implication, sampled on clk, off during rst.
`define MCMD_ASSERT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off during rst.
`define MCMD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### src/mcmd_pkg.sv
// Package: payload types, event codes and MIDI constants for the decoder.
`timescale 1ns / 1ps
package mcmd_pkg;

  typedef struct packed {
    logic [7:0] status_byte;
    logic [7:0] data_one;
    logic [7:0] data_two;
  } msg_t;

  typedef struct packed {
    logic [3:0] event_kind;
    logic [3:0] channel_out;
    logic [6:0] value_one;
    logic [7:0] value_two;
  } evt_t;

  // Event kinds
  localparam logic [3:0] EV_NONE        = 4'd0;
  localparam logic [3:0] EV_NOTEOFF     = 4'd1;
  localparam logic [3:0] EV_NOTEON      = 4'd2;
  localparam logic [3:0] EV_KEYPRESSURE = 4'd3;
  localparam logic [3:0] EV_VOLUME      = 4'd4;
  localparam logic [3:0] EV_PAN         = 4'd5;
  localparam logic [3:0] EV_EXPRESSION  = 4'd6;
  localparam logic [3:0] EV_SUSTAIN     = 4'd7;
  localparam logic [3:0] EV_SOUNDSOFF   = 4'd8;
  localparam logic [3:0] EV_RESETCTL    = 4'd9;
  localparam logic [3:0] EV_NOTESOFF    = 4'd10;
  localparam logic [3:0] EV_BANK        = 4'd11;
  localparam logic [3:0] EV_PITCHSENS   = 4'd12;
  localparam logic [3:0] EV_PROGRAM     = 4'd13;
  localparam logic [3:0] EV_PITCHWHEEL  = 4'd14;

  // Status bytes that carry no channel event
  localparam logic [7:0] ST_SYSEX     = 8'hF0;
  localparam logic [7:0] ST_SYSEX_END = 8'hF7;
  localparam logic [7:0] ST_META      = 8'hFF;

  // Status groups (bits 6:4 of the status byte)
  localparam logic [2:0] GRP_NOTEOFF    = 3'd0;
  localparam logic [2:0] GRP_NOTEON     = 3'd1;
  localparam logic [2:0] GRP_KEYPRESS   = 3'd2;
  localparam logic [2:0] GRP_CONTROL    = 3'd3;
  localparam logic [2:0] GRP_PROGRAM    = 3'd4;
  localparam logic [2:0] GRP_PITCHWHEEL = 3'd6;

  // Controller numbers
  localparam logic [6:0] CTL_BANK       = 7'd0;
  localparam logic [6:0] CTL_DATA_ENTRY = 7'd6;
  localparam logic [6:0] CTL_VOLUME     = 7'd7;
  localparam logic [6:0] CTL_PAN        = 7'd10;
  localparam logic [6:0] CTL_EXPRESSION = 7'd11;
  localparam logic [6:0] CTL_SUSTAIN    = 7'd64;
  localparam logic [6:0] CTL_NRPN_LSB   = 7'd98;
  localparam logic [6:0] CTL_NRPN_MSB   = 7'd99;
  localparam logic [6:0] CTL_RPN_LSB    = 7'd100;
  localparam logic [6:0] CTL_RPN_MSB    = 7'd101;
  localparam logic [6:0] CTL_SOUNDSOFF  = 7'd120;
  localparam logic [6:0] CTL_RESETCTL   = 7'd121;
  localparam logic [6:0] CTL_NOTESOFF   = 7'd123;

  // Parameter numbers recognized by data entry
  localparam logic [15:0] PARAM_PITCH_SENS = 16'h0000;
  localparam logic [15:0] PARAM_NULL       = 16'h7F7F;

  // Values sent for the null parameter
  localparam logic [6:0] NULL_VALUE_ONE = 7'd2;
  localparam logic [7:0] NULL_VALUE_TWO = 8'd0;

endpackage

### src/mcmd_stream_if.sv
// Valid/ready stream interface with a typed payload.
`timescale 1ns / 1ps
interface mcmd_stream_if #(
  parameter type payload_t = logic [7:0]
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

### src/midi_channel_message_decoder_unit.sv
// Top level: MIDI channel message decoder with per-channel parameter numbers.
// Path from msg acceptance to evt: input register, then result register.
// Throughput: one item per cycle; msg stalls only while evt holds an untaken item
// and the input register is full.
// Reset (synchronous, rst high): pipeline emptied, parameter numbers of all
// 16 channels and the NRPN flag cleared.
`timescale 1ns / 1ps
`include "midi_channel_message_decoder_unit_macros.svh"
module midi_channel_message_decoder_unit (
  input  logic          clk,
  input  logic          rst,
  mcmd_stream_if.sink   msg,
  mcmd_stream_if.source evt
);
  import mcmd_pkg::*;

  logic       s1_valid;
  msg_t       s1_msg;
  logic       evt_valid;
  evt_t       evt_data;
  logic       advance;
  logic       commit;

  logic [7:0] param_high [16];
  logic [7:0] param_low  [16];
  logic       nrpn_flag;

  logic [3:0]  chan;
  logic [6:0]  v1;
  logic [7:0]  v2;
  logic        is_status;
  logic [15:0] param_num;
  logic [3:0]  kind;
  logic [6:0]  val_one;
  logic [7:0]  val_two;
  logic        high_we;
  logic        low_we;
  logic        flag_we;
  logic        flag_val;
  evt_t        result;

  assign advance   = !evt_valid || evt.ready;
  assign commit    = s1_valid && advance;
  assign msg.ready = !s1_valid || advance;

  assign evt.valid   = evt_valid;
  assign evt.payload = evt_data;

  // ---- decode ----
  assign chan      = s1_msg.status_byte[3:0];
  assign v1        = s1_msg.data_one[6:0];
  assign v2        = s1_msg.data_two;
  assign is_status = s1_msg.status_byte[7] && (s1_msg.status_byte != ST_SYSEX) &&
                     (s1_msg.status_byte != ST_SYSEX_END) && (s1_msg.status_byte != ST_META);
  assign param_num = {param_high[chan], param_low[chan]};

  always_comb begin
    kind     = EV_NONE;
    val_one  = v1;
    val_two  = v2;
    high_we  = 1'b0;
    low_we   = 1'b0;
    flag_we  = 1'b0;
    flag_val = 1'b0;
    if (is_status) begin
      unique case (s1_msg.status_byte[6:4])
        GRP_NOTEOFF:    kind = EV_NOTEOFF;
        GRP_NOTEON:     kind = EV_NOTEON;
        GRP_KEYPRESS:   kind = EV_KEYPRESSURE;
        GRP_PROGRAM:    kind = EV_PROGRAM;
        GRP_PITCHWHEEL: kind = EV_PITCHWHEEL;
        GRP_CONTROL: begin
          unique case (v1)
            CTL_VOLUME:     kind = EV_VOLUME;
            CTL_PAN:        kind = EV_PAN;
            CTL_EXPRESSION: kind = EV_EXPRESSION;
            CTL_SUSTAIN:    kind = EV_SUSTAIN;
            CTL_SOUNDSOFF:  kind = EV_SOUNDSOFF;
            CTL_RESETCTL:   kind = EV_RESETCTL;
            CTL_NOTESOFF:   kind = EV_NOTESOFF;
            CTL_BANK:       kind = EV_BANK;
            CTL_RPN_MSB: begin
              high_we = 1'b1;
              flag_we = 1'b1;
            end
            CTL_RPN_LSB: begin
              low_we  = 1'b1;
              flag_we = 1'b1;
            end
            CTL_NRPN_MSB: begin
              high_we  = 1'b1;
              flag_we  = 1'b1;
              flag_val = 1'b1;
            end
            CTL_NRPN_LSB: begin
              low_we   = 1'b1;
              flag_we  = 1'b1;
              flag_val = 1'b1;
            end
            CTL_DATA_ENTRY: begin
              if (!nrpn_flag && param_num == PARAM_PITCH_SENS) begin
                kind = EV_PITCHSENS;
              end else if (!nrpn_flag && param_num == PARAM_NULL) begin
                kind    = EV_PITCHSENS;
                val_one = NULL_VALUE_ONE;
                val_two = NULL_VALUE_TWO;
              end
            end
            default: kind = EV_NONE;
          endcase
        end
        default: kind = EV_NONE;
      endcase
    end
  end

  always_comb begin
    if (kind == EV_NONE) begin
      result = '0;
    end else begin
      result.event_kind  = kind;
      result.channel_out = chan;
      result.value_one   = val_one;
      result.value_two   = val_two;
    end
  end

  // ---- pipeline registers ----
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      evt_valid <= 1'b0;
    end else begin
      if (msg.ready) s1_valid <= msg.valid;
      if (advance) evt_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (msg.valid && msg.ready) s1_msg <= msg.payload;
    if (commit) evt_data <= result;
  end

  // ---- parameter number state, updated as the item moves to the result register ----
  always_ff @(posedge clk) begin
    if (rst) begin
      nrpn_flag <= 1'b0;
      for (int i = 0; i < 16; i++) begin
        param_high[i] <= '0;
        param_low[i]  <= '0;
      end
    end else if (commit) begin
      if (flag_we) nrpn_flag <= flag_val;
      if (high_we) param_high[chan] <= v2;
      if (low_we) param_low[chan] <= v2;
    end
  end

  // ---- assertions ----
  `MCMD_ASSERT(a_none_zero, evt.valid && evt.payload.event_kind == EV_NONE,
    evt.payload.channel_out == 4'd0 && evt.payload.value_one == 7'd0 &&
    evt.payload.value_two == 8'd0, "no-event item carries nonzero fields")
  `MCMD_ASSERT(a_event_needs_status, commit && kind != EV_NONE, s1_msg.status_byte[7],
    "event decoded from a data byte")
  `MCMD_ASSERT_NEXT(a_rpn_clears_flag, commit && flag_we && !flag_val, !nrpn_flag,
    "RPN select left NRPN flag set")
  `MCMD_ASSERT_NEXT(a_nrpn_sets_flag, commit && flag_we && flag_val, nrpn_flag,
    "NRPN select did not set flag")
  `MCMD_ASSERT(a_pitchsens_rpn, commit && kind == EV_PITCHSENS, !nrpn_flag,
    "pitch sensitivity while NRPN selected")

endmodule
